FILE: design/okal_pkg.sv
package okal_pkg;

   localparam int KEY_W = 64;
   localparam int REC_W = 64;
   localparam int CMD_W = 3;
   localparam int POS_W = 5;
   localparam int STS_W = 3;
   localparam int CNT_FIELD_W = 5;

   typedef enum logic [CMD_W-1:0] {
      CMD_INS_FRONT  = 3'd0,
      CMD_INS_BACK   = 3'd1,
      CMD_INS_UNIQUE = 3'd2,
      CMD_INS_AT     = 3'd3,
      CMD_DELETE     = 3'd4
   } okal_cmd_type;

   typedef enum logic [STS_W-1:0] {
      STS_OK       = 3'd0,
      STS_FULL     = 3'd1,
      STS_BADPOS   = 3'd2,
      STS_DUP      = 3'd3,
      STS_NOTFOUND = 3'd4,
      STS_EMPTY    = 3'd5
   } okal_status_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_CMP  = 2'd1,
      ST_EXEC = 2'd2
   } okal_state_type;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic [KEY_W-1:0] entry_key;
      logic [REC_W-1:0] entry_record;
      logic [POS_W-1:0] position;
   } okal_req_type;

   typedef struct packed {
      logic [STS_W-1:0]       status;
      logic [KEY_W-1:0]       removed_key;
      logic [REC_W-1:0]       removed_record;
      logic [CNT_FIELD_W-1:0] entry_count;
   } okal_rsp_type;

   // control broadcast to every cell of the chain
   typedef struct packed {
      logic             cmp_en;
      logic             ins_go;
      logic             del_go;
      logic [KEY_W-1:0] key;
      logic [REC_W-1:0] record;
   } okal_cell_ctl_type;

endpackage

FILE: design/okal_cell.sv
module okal_cell (
   input  logic                      clock,
   input  okal_pkg::okal_cell_ctl_type ctl,
   input  logic                      in_range,
   input  logic                      at_pos,
   input  logic                      above_pos,
   input  logic [okal_pkg::KEY_W-1:0] lower_key,
   input  logic [okal_pkg::REC_W-1:0] lower_rec,
   input  logic [okal_pkg::KEY_W-1:0] upper_key,
   input  logic [okal_pkg::REC_W-1:0] upper_rec,
   input  logic                      seen_in,
   output logic [okal_pkg::KEY_W-1:0] key,
   output logic [okal_pkg::REC_W-1:0] rec,
   output logic                      seen_out,
   output logic                      first
);

   logic [okal_pkg::KEY_W-1:0] key_ff, key_in;
   logic [okal_pkg::REC_W-1:0] rec_ff, rec_in;
   logic                       match_ff, match_in;

   // any match at or below this cell means this cell moves down on delete
   assign seen_out = seen_in | match_ff;
   assign first    = match_ff & ~seen_in;
   assign key      = key_ff;
   assign rec      = rec_ff;

   always_comb begin
      match_in = match_ff;
      if (ctl.cmp_en) begin
         match_in = in_range && (key_ff == ctl.key);
      end
   end

   always_comb begin
      key_in = key_ff;
      rec_in = rec_ff;
      if (ctl.ins_go) begin
         if (at_pos) begin
            key_in = ctl.key;
            rec_in = ctl.record;
         end else if (above_pos) begin
            key_in = lower_key;
            rec_in = lower_rec;
         end
      end else if (ctl.del_go && seen_out) begin
         key_in = upper_key;
         rec_in = upper_rec;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      rec_ff   <= rec_in;
      match_ff <= match_in;
   end

endmodule

FILE: design/ordered_keyed_array_list_unit.sv
// an accepted request goes through the compare state and then the execute state, which loads the response register
// one transaction at a time (accept, compare in all cells, shift); a new request is taken only after the shift
// the response register frees the request side; a stalled response delays the shift step
// synchronous reset empties the list and drops any pending response
// entry contents are not cleared by reset
module ordered_keyed_array_list_unit #(
   parameter int DEPTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  okal_pkg::okal_req_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output okal_pkg::okal_rsp_type rsp_data
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > okal_pkg::POS_W) ? CNT_W : okal_pkg::POS_W;

   okal_pkg::okal_state_type state_ff, state_in;
   okal_pkg::okal_req_type   cmd_ff, cmd_in;
   okal_pkg::okal_rsp_type   rsp_ff, rsp_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]         count_ff, count_in;

   logic                       accept;
   logic                       exec_go;
   logic                       cmp_en;
   logic                       do_ins, do_del, full, found;
   okal_pkg::okal_status_type  status;
   logic [CMP_W-1:0]           ins_idx;
   logic [okal_pkg::KEY_W-1:0] rem_key;
   logic [okal_pkg::REC_W-1:0] rem_rec;
   okal_pkg::okal_cell_ctl_type ctl;

   logic [DEPTH-1:0]           in_range, at_pos, above_pos, first;
   logic [DEPTH:0]             seen;
   logic [okal_pkg::KEY_W-1:0] cell_key  [DEPTH];
   logic [okal_pkg::REC_W-1:0] cell_rec  [DEPTH];
   logic [okal_pkg::KEY_W-1:0] lower_key [DEPTH];
   logic [okal_pkg::REC_W-1:0] lower_rec [DEPTH];
   logic [okal_pkg::KEY_W-1:0] upper_key [DEPTH];
   logic [okal_pkg::REC_W-1:0] upper_rec [DEPTH];

   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         okal_pkg::ST_IDLE: if (req_valid) state_in = okal_pkg::ST_CMP;
         okal_pkg::ST_CMP:  state_in = okal_pkg::ST_EXEC;
         okal_pkg::ST_EXEC: if (!(rsp_valid_ff && rsp_stall)) state_in = okal_pkg::ST_IDLE;
         default:           state_in = okal_pkg::ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_stall = 1'b1;
      exec_go   = 1'b0;
      cmp_en    = 1'b0;
      case (state_ff)
         okal_pkg::ST_IDLE: req_stall = 1'b0;
         okal_pkg::ST_CMP:  cmp_en = 1'b1;
         okal_pkg::ST_EXEC: exec_go = !(rsp_valid_ff && rsp_stall);
         default:           req_stall = 1'b1;
      endcase
   end

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign found = seen[DEPTH];

   always_comb begin
      do_ins  = 1'b0;
      do_del  = 1'b0;
      status  = okal_pkg::STS_OK;
      ins_idx = '0;
      case (okal_pkg::okal_cmd_type'(cmd_ff.cmd))
         okal_pkg::CMD_INS_FRONT: begin
            if (full) status = okal_pkg::STS_FULL;
            else do_ins = 1'b1;
         end
         okal_pkg::CMD_INS_BACK: begin
            ins_idx = CMP_W'(count_ff);
            if (full) status = okal_pkg::STS_FULL;
            else do_ins = 1'b1;
         end
         okal_pkg::CMD_INS_UNIQUE: begin
            ins_idx = CMP_W'(count_ff);
            if (full) status = okal_pkg::STS_FULL;
            else if (found) status = okal_pkg::STS_DUP;
            else do_ins = 1'b1;
         end
         okal_pkg::CMD_INS_AT: begin
            ins_idx = CMP_W'(cmd_ff.position);
            if (full) status = okal_pkg::STS_FULL;
            else if (CMP_W'(cmd_ff.position) > CMP_W'(count_ff)) status = okal_pkg::STS_BADPOS;
            else do_ins = 1'b1;
         end
         okal_pkg::CMD_DELETE: begin
            if (count_ff == '0) status = okal_pkg::STS_EMPTY;
            else if (found) do_del = 1'b1;
            else status = okal_pkg::STS_NOTFOUND;
         end
         default: status = okal_pkg::STS_OK;
      endcase
   end

   assign ctl.cmp_en = cmp_en;
   assign ctl.ins_go = exec_go && do_ins;
   assign ctl.del_go = exec_go && do_del;
   assign ctl.key    = cmd_ff.entry_key;
   assign ctl.record = cmd_ff.entry_record;

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         in_range[i]  = CNT_W'(i) < count_ff;
         at_pos[i]    = ins_idx == CMP_W'(i);
         above_pos[i] = ins_idx < CMP_W'(i);
      end
   end

   // pick the entry at the lowest matching index
   always_comb begin
      rem_key = '0;
      rem_rec = '0;
      for (int i = 0; i < DEPTH; i++) begin
         rem_key = rem_key | ({okal_pkg::KEY_W{first[i]}} & cell_key[i]);
         rem_rec = rem_rec | ({okal_pkg::REC_W{first[i]}} & cell_rec[i]);
      end
      if (!do_del) begin
         rem_key = '0;
         rem_rec = '0;
      end
   end

   assign seen[0] = 1'b0;

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      if (g == 0) begin : g_bottom
         assign lower_key[g] = cell_key[g];
         assign lower_rec[g] = cell_rec[g];
      end else begin : g_mid_lo
         assign lower_key[g] = cell_key[g-1];
         assign lower_rec[g] = cell_rec[g-1];
      end
      if (g == DEPTH - 1) begin : g_top
         assign upper_key[g] = cell_key[g];
         assign upper_rec[g] = cell_rec[g];
      end else begin : g_mid_hi
         assign upper_key[g] = cell_key[g+1];
         assign upper_rec[g] = cell_rec[g+1];
      end

      okal_cell u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .in_range  (in_range[g]),
         .at_pos    (at_pos[g]),
         .above_pos (above_pos[g]),
         .lower_key (lower_key[g]),
         .lower_rec (lower_rec[g]),
         .upper_key (upper_key[g]),
         .upper_rec (upper_rec[g]),
         .seen_in   (seen[g]),
         .key       (cell_key[g]),
         .rec       (cell_rec[g]),
         .seen_out  (seen[g+1]),
         .first     (first[g])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (ctl.ins_go) count_in = count_ff + CNT_W'(1);
      else if (ctl.del_go) count_in = count_ff - CNT_W'(1);
   end

   always_comb begin
      cmd_in = cmd_ff;
      if (accept) cmd_in = req_data;
   end

   always_comb begin
      rsp_in = rsp_ff;
      if (exec_go) begin
         rsp_in.status         = status;
         rsp_in.removed_key    = rem_key;
         rsp_in.removed_record = rem_rec;
         rsp_in.entry_count    = okal_pkg::CNT_FIELD_W'(count_in);
      end
   end

   assign rsp_valid_in = exec_go || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= okal_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      rsp_ff <= rsp_in;
   end

endmodule

FILE: design/okal_checker.sv
module okal_checker #(
   parameter int DEPTH = 16
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input okal_pkg::okal_rsp_type rsp_data
);

   // a held response keeps its contents
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // one transaction in flight: request side closes right after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second request taken while busy");

   a_removed_only_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.removed_key != '0 || rsp_data.removed_record != '0)
      |-> rsp_data.status == okal_pkg::STS_OK)
      else $error("removed entry reported with failing status");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == okal_pkg::STS_FULL
      |-> rsp_data.entry_count == okal_pkg::CNT_FIELD_W'(DEPTH))
      else $error("full status with count below depth");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (DEPTH > 31) || (int'(rsp_data.entry_count) <= DEPTH))
      else $error("entry count above depth");

endmodule

bind ordered_keyed_array_list_unit okal_checker #(.DEPTH(DEPTH)) u_okal_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
